### src/ring_entry_offset_locator_defines.svh
// Assertion macros shared by the block's checker.
// No dependencies; include by bare file name.
`ifndef RING_ENTRY_OFFSET_LOCATOR_DEFINES_SVH
`define RING_ENTRY_OFFSET_LOCATOR_DEFINES_SVH

// Same-cycle implication, clocked on clock, quiet during reset.
`define REL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, quiet during reset.
`define REL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/rel_pkg.sv
// Shared types for the ring entry offset locator: request/response beats,
// the search token passed along the cell chain and the per-cell result.
// No dependencies.
package rel_pkg;

   typedef enum logic {
      REQ_ADD  = 1'b0,
      REQ_FIND = 1'b1
   } rel_op_type;

   typedef struct packed {
      rel_op_type  req_type;
      logic [31:0] entry_addr;
      logic [15:0] entry_size;
      logic [19:0] text_offset;
   } rel_req_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  slot;
      logic [31:0] match_addr;
      logic [15:0] match_size;
      logic [15:0] byte_in_entry;
   } rel_rsp_type;

   // search token: characters still to skip before the wanted one
   typedef struct packed {
      logic        valid;
      logic [19:0] remaining;
   } rel_tok_type;

   // what a cell reports in the cycle the token visits it
   typedef struct packed {
      logic        hit;
      logic        miss;
      logic [31:0] addr;
      logic [15:0] size;
      logic [15:0] byte_off;
   } rel_hit_type;

endpackage

### src/rel_cell.sv
// One ring slot: holds an entry and tests / forwards the search token.
// Depends on rel_pkg.
module rel_cell #(
   parameter int CNT_W = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [31:0]          wr_addr,
   input  logic [15:0]          wr_size,
   input  rel_pkg::rel_tok_type up_tok,
   input  logic [CNT_W-1:0]     up_left,
   output rel_pkg::rel_tok_type dn_tok,
   output logic [CNT_W-1:0]     dn_left,
   output rel_pkg::rel_hit_type result
);
   import rel_pkg::*;

   logic [31:0]      addr_ff;
   logic [15:0]      size_ff;
   rel_tok_type      tok_ff, tok_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             is_match;
   logic             is_last;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         addr_ff <= wr_addr;
         size_ff <= wr_size;
      end
   end

   always_comb begin
      is_match = up_tok.valid && (size_ff != 16'd0)
                 && (up_tok.remaining < {4'd0, size_ff});
      is_last  = (up_left == CNT_W'(1));

      result.hit      = is_match;
      result.miss     = up_tok.valid && !is_match && is_last;
      result.addr     = addr_ff;
      result.size     = size_ff;
      result.byte_off = up_tok.remaining[15:0];

      // zero-size entries fall through here: subtracting zero skips them
      tok_in.valid     = up_tok.valid && !is_match && !is_last;
      tok_in.remaining = up_tok.remaining - {4'd0, size_ff};
      left_in          = up_left - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.remaining <= tok_in.remaining;
      left_ff          <= left_in;
   end

   assign dn_tok  = tok_ff;
   assign dn_left = left_ff;

endmodule

### src/ring_entry_offset_locator.sv
// Top level of the ring entry offset locator: slot pointers, request
// handling and a ring of rel_cell slots that a find token walks.
// Depends on rel_pkg and rel_cell.
//
//   channel | ports                       | handshake
//   --------+-----------------------------+-----------------------------------
//   request | start, busy, req_data       | beat taken when start && !busy
//   result  | rsp_strobe, rsp_data        | beat valid for one cycle, no stall
//
// Flow: an add beat never raises busy, and the next beat may follow right
// after. A find raises busy while its token hops one cell per clock from
// the oldest slot; the last visited cell's hit or miss is registered as
// the strobe, and busy drops as the strobe shows, so the next beat can be
// taken in that same cycle. A find on an empty ring strobes in the cycle
// after its accept.
// Reset: synchronous, active high; clears pointers, full flag, busy and the
// token chain. Entry contents are not cleared; only written slots are read.
// Stalls: none on the result side; the receiver takes every strobed beat.
module ring_entry_offset_locator #(
   parameter int RING_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  rel_pkg::rel_req_type req_data,
   output logic                 rsp_strobe,
   output rel_pkg::rel_rsp_type rsp_data
);
   import rel_pkg::*;

   localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W  = $clog2(RING_DEPTH + 1);

   // pointers and flags
   logic [SLOT_W-1:0] write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0] oldest_slot_ff, oldest_slot_in;
   logic              full_ff, full_in;
   logic              busy_ff, busy_in;

   // token injection into the oldest cell
   logic              inj_valid_ff, inj_valid_in;
   logic [19:0]       inj_rem_ff, inj_rem_in;
   logic [CNT_W-1:0]  inj_left_ff, inj_left_in;
   logic [SLOT_W-1:0] inj_slot_ff, inj_slot_in;

   // result register
   logic              rsp_strobe_ff, rsp_strobe_in;
   rel_rsp_type       rsp_ff, rsp_in;

   // cell chain
   rel_tok_type       up_tok  [RING_DEPTH];
   logic [CNT_W-1:0]  up_left [RING_DEPTH];
   rel_tok_type       dn_tok  [RING_DEPTH];
   logic [CNT_W-1:0]  dn_left [RING_DEPTH];
   rel_hit_type       cell_res[RING_DEPTH];
   logic [RING_DEPTH-1:0] wr_en;

   logic              accept;
   logic [SLOT_W-1:0] wr_next;
   logic [CNT_W-1:0]  stored_cnt;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      next_slot = (s == SLOT_W'(RING_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
   endfunction

   assign accept = start && !busy_ff;

   // entries held: wraps modulo the CNT_W-bit width, result always < 2**CNT_W
   always_comb begin
      if (full_ff) begin
         stored_cnt = CNT_W'(RING_DEPTH);
      end else begin
         stored_cnt = CNT_W'(write_slot_ff) - CNT_W'(oldest_slot_ff)
                      + ((write_slot_ff < oldest_slot_ff) ? CNT_W'(RING_DEPTH) : '0);
      end
   end

   always_comb begin
      write_slot_in  = write_slot_ff;
      oldest_slot_in = oldest_slot_ff;
      full_in        = full_ff;
      busy_in        = busy_ff;
      inj_valid_in   = 1'b0;
      inj_rem_in     = req_data.text_offset;
      inj_left_in    = stored_cnt;
      inj_slot_in    = oldest_slot_ff;
      rsp_strobe_in  = 1'b0;
      rsp_in         = rsp_ff;
      wr_next        = next_slot(write_slot_ff);

      if (accept && req_data.req_type == REQ_ADD) begin
         // overwrite the oldest entry once the ring is full
         if (full_ff) begin
            oldest_slot_in = next_slot(oldest_slot_ff);
         end
         write_slot_in = wr_next;
         if (wr_next == oldest_slot_in) begin
            full_in = 1'b1;
         end
      end else if (accept) begin
         if (stored_cnt == '0) begin
            rsp_strobe_in = 1'b1;
            rsp_in        = '0;
         end else begin
            inj_valid_in = 1'b1;
            busy_in      = 1'b1;
         end
      end

      // token finished somewhere in the ring: at most one cell reports
      for (int k = 0; k < RING_DEPTH; k++) begin
         if (cell_res[k].hit) begin
            rsp_strobe_in        = 1'b1;
            busy_in              = 1'b0;
            rsp_in.found         = 1'b1;
            rsp_in.slot          = 4'(k);
            rsp_in.match_addr    = cell_res[k].addr;
            rsp_in.match_size    = cell_res[k].size;
            rsp_in.byte_in_entry = cell_res[k].byte_off;
         end else if (cell_res[k].miss) begin
            rsp_strobe_in = 1'b1;
            busy_in       = 1'b0;
            rsp_in        = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff  <= '0;
         oldest_slot_ff <= '0;
         full_ff        <= 1'b0;
         busy_ff        <= 1'b0;
         inj_valid_ff   <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         write_slot_ff  <= write_slot_in;
         oldest_slot_ff <= oldest_slot_in;
         full_ff        <= full_in;
         busy_ff        <= busy_in;
         inj_valid_ff   <= inj_valid_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
      inj_rem_ff  <= inj_rem_in;
      inj_left_ff <= inj_left_in;
      inj_slot_ff <= inj_slot_in;
      rsp_ff      <= rsp_in;
   end

   // ring of cells; the token enters at the oldest slot and moves upward
   for (genvar k = 0; k < RING_DEPTH; k++) begin : g_cell
      localparam int PREV = (k + RING_DEPTH - 1) % RING_DEPTH;
      logic inj_here;

      assign inj_here = inj_valid_ff && (inj_slot_ff == SLOT_W'(k));
      assign wr_en[k] = accept && (req_data.req_type == REQ_ADD)
                        && (write_slot_ff == SLOT_W'(k));

      always_comb begin
         if (inj_here) begin
            up_tok[k].valid     = 1'b1;
            up_tok[k].remaining = inj_rem_ff;
            up_left[k]          = inj_left_ff;
         end else begin
            up_tok[k]  = dn_tok[PREV];
            up_left[k] = dn_left[PREV];
         end
      end

      rel_cell #(
         .CNT_W (CNT_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .wr_en   (wr_en[k]),
         .wr_addr (req_data.entry_addr),
         .wr_size (req_data.entry_size),
         .up_tok  (up_tok[k]),
         .up_left (up_left[k]),
         .dn_tok  (dn_tok[k]),
         .dn_left (dn_left[k]),
         .result  (cell_res[k])
      );
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

### src/rel_checker.sv
// Port-level checks for ring_entry_offset_locator, bound to the top level.
// Depends on rel_pkg and ring_entry_offset_locator_defines.svh.
`include "ring_entry_offset_locator_defines.svh"

module rel_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input rel_pkg::rel_req_type req_data,
   input logic                 rsp_strobe,
   input rel_pkg::rel_rsp_type rsp_data
);
   import rel_pkg::*;

   logic miss_zero;
   logic add_taken;

   assign miss_zero = rsp_data.slot == 4'd0 && rsp_data.match_addr == 32'd0
                      && rsp_data.match_size == 16'd0 && rsp_data.byte_in_entry == 16'd0;
   assign add_taken = start && !busy && req_data.req_type == REQ_ADD;

   // not-found beats carry all-zero fields
   `REL_ASSERT_NOW(a_miss_zero, rsp_strobe && !rsp_data.found, miss_zero, "nonzero miss beat")

   // a match points inside its entry
   `REL_ASSERT_NOW(a_hit_inside, rsp_strobe && rsp_data.found, rsp_data.byte_in_entry < rsp_data.match_size, "offset outside entry")

   // an add never starts a search
   `REL_ASSERT_NEXT(a_add_quiet, add_taken, !busy, "add beat raised busy")

   // a search only ends by delivering its beat
   `REL_ASSERT_NOW(a_end_strobe, $fell(busy) && !$past(reset), rsp_strobe, "busy fell, no beat")

endmodule

bind ring_entry_offset_locator rel_checker u_rel_checker (.*);
